// File: rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  // Default number of digits per coordinate
  localparam int DIGITS_DEF = 3;

  // Queue between parser and LCD sequencer
  localparam int QUEUE_DEPTH = 4;

  // Idle counter and threshold
  localparam int           THRESH_W     = 4;
  localparam logic [3:0]   THRESH_RESET = 4'd3;
  localparam logic [3:0]   IDLE_RESET   = 4'd3;
  localparam logic [3:0]   IDLE_MAX     = 4'hF;

  // Byte classes and keys
  localparam logic [7:0] DIGIT_MAX = 8'h39;
  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_X     = 8'h58;
  localparam logic [7:0] KEY_Y     = 8'h59;
  localparam logic [7:0] KEY_Z     = 8'h5A;

  // LCD characters and cursor commands
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CURSOR_X  = 8'h80;
  localparam logic [7:0] CURSOR_Y  = 8'h88;
  localparam logic [7:0] CURSOR_Z  = 8'hC0;

  // Beat positions within an LCD update
  localparam int BEAT_CURSOR = 0;
  localparam int BEAT_LETTER = 1;
  localparam int BEAT_EQUAL  = 2;
  localparam int BEAT_DIGIT0 = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // One queued job for the LCD sequencer
  typedef struct packed {
    logic  write;
    axis_t axis;
    logic  led;
  } cfp_cmd_t;

  function automatic logic [7:0] cursor_cmd(input axis_t axis);
    logic [7:0] c;
    case (axis)
      AXIS_X:  c = CURSOR_X;
      AXIS_Y:  c = CURSOR_Y;
      AXIS_Z:  c = CURSOR_Z;
      default: c = CURSOR_X;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfp_in_if.sv
`default_nettype none

interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/cfp_out_if.sv
`default_nettype none

interface cfp_out_if;
  logic       valid;
  logic       ready;
  logic       lcd_valid;
  logic       lcd_is_command;
  logic [7:0] lcd_byte;
  logic       led_on;
  logic       last;

  modport source (output valid, output lcd_valid, output lcd_is_command, output lcd_byte,
                  output led_on, output last, input ready);
  modport sink   (input valid, input lcd_valid, input lcd_is_command, input lcd_byte,
                  input led_on, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/coord_frame_parser_lcd_update.sv
// Coordinate frame parser with LCD update. Each input beat is a received bus byte (kind 0)
// or a timer tick (kind 1). A parser takes one beat per clock while its job queue
// (QUEUE_DEPTH entries) has room. A commit that changes an axis value yields DIGITS+3
// output beats (cursor command, letter, '=', digits), and any other input yields a single
// output beat; the final beat of each input is marked by last. An input is first written
// into the queue and then loaded into the LCD sequencer's job register before its first
// output beat is offered. The LCD sequencer sends one beat per clock while out_ch.ready
// is high; the queue absorbs bursts so input and output stall independently. The user
// must write idle_threshold through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module coord_frame_parser_lcd_update #(
  parameter int DIGITS = cfp_pkg::DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [cfp_pkg::THRESH_W-1:0] cfg_wr_data,
  cfp_in_if.sink                            in_ch,
  cfp_out_if.source                         out_ch
);
  import cfp_pkg::*;

  localparam int QW = $bits(cfp_cmd_t) + 8 * DIGITS;

  logic                   q_full, q_empty, q_push, q_pop;
  cfp_cmd_t               push_cmd, pop_cmd;
  logic [DIGITS-1:0][7:0] push_digits, pop_digits;
  logic [QW-1:0]          q_wr_data, q_rd_data;

  cfp_front #(.DIGITS(DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_digits   (push_digits)
  );

  assign q_wr_data = {push_cmd, push_digits};

  cfp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  assign {pop_cmd, pop_digits} = q_rd_data;

  cfp_back #(.DIGITS(DIGITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cmd   (pop_cmd),
    .q_digits(pop_digits),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/cfp_front.sv
`default_nettype none

module cfp_front #(
  parameter int DIGITS = cfp_pkg::DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [cfp_pkg::THRESH_W-1:0] cfg_wr_data,
  cfp_in_if.sink                            in_ch,
  input  wire logic                         q_full,
  output logic                              q_push,
  output cfp_pkg::cfp_cmd_t                 q_cmd,
  output logic [DIGITS-1:0][7:0]            q_digits
);
  import cfp_pkg::*;

  localparam int CW = $clog2(DIGITS + 1);

  logic [THRESH_W-1:0]      idle_threshold;
  logic [7:0]               held_key, held_key_next;
  logic [DIGITS-1:0][7:0]   digit_buffer, digit_buffer_next, buf_fill;
  logic [CW-1:0]            digit_count, digit_count_next;
  logic [DIGITS-1:0][7:0]   shown_coords [3];
  logic [DIGITS-1:0][7:0]   shown_next [3];
  logic [3:0]               idle_ticks, idle_ticks_next;
  logic                     led_level, led_level_next;
  logic                     axis_hit, write_lcd;
  axis_t                    axis_sel;

  // Accept a beat whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Parse one beat
  always_comb begin
    held_key_next     = held_key;
    digit_count_next  = digit_count;
    buf_fill          = digit_buffer;
    digit_buffer_next = digit_buffer;
    shown_next        = shown_coords;
    idle_ticks_next   = idle_ticks;
    led_level_next    = led_level;
    axis_hit          = 1'b0;
    axis_sel          = AXIS_X;
    write_lcd         = 1'b0;
    if (in_ch.kind) begin
      if (idle_ticks >= idle_threshold) led_level_next = ~led_level;
      if (idle_ticks != IDLE_MAX) idle_ticks_next = idle_ticks + 4'd1;
    end else begin
      if (in_ch.rx_byte > DIGIT_MAX) begin
        held_key_next = in_ch.rx_byte;
      end else if (digit_count < CW'(DIGITS)) begin
        for (int i = 0; i < DIGITS; i++) begin
          if (digit_count == CW'(i)) buf_fill[i] = in_ch.rx_byte;
        end
        digit_count_next = digit_count + CW'(1);
      end
      digit_buffer_next = buf_fill;
      // Commit once the frame is complete
      if (digit_count_next == CW'(DIGITS) && held_key_next > DIGIT_MAX) begin
        unique case (held_key_next)
          KEY_X: begin axis_hit = 1'b1; axis_sel = AXIS_X; end
          KEY_Y: begin axis_hit = 1'b1; axis_sel = AXIS_Y; end
          KEY_Z: begin axis_hit = 1'b1; axis_sel = AXIS_Z; end
          default: axis_hit = 1'b0;
        endcase
        if (axis_hit) begin
          write_lcd            = (shown_coords[axis_sel] != buf_fill);
          shown_next[axis_sel] = buf_fill;
        end
        held_key_next     = KEY_NONE;
        digit_count_next  = '0;
        digit_buffer_next = '0;
      end
      led_level_next  = 1'b1;
      idle_ticks_next = '0;
    end
  end

  // Queue job
  always_comb begin
    q_cmd.write = write_lcd;
    q_cmd.axis  = axis_sel;
    q_cmd.led   = led_level_next;
    q_digits    = buf_fill;
  end

  // Hold threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      idle_threshold <= cfg_wr_data;
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_key     <= KEY_NONE;
      digit_buffer <= '0;
      digit_count  <= '0;
      for (int a = 0; a < 3; a++) begin
        shown_coords[a] <= {DIGITS{CHAR_ZERO}};
      end
      idle_ticks   <= IDLE_RESET;
      led_level    <= 1'b0;
    end else if (q_push) begin
      held_key     <= held_key_next;
      digit_buffer <= digit_buffer_next;
      digit_count  <= digit_count_next;
      shown_coords <= shown_next;
      idle_ticks   <= idle_ticks_next;
      led_level    <= led_level_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfp_queue.sv
`default_nettype none

module cfp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cfp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  import cfp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_wr, do_rd;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd)      fill <= fill + NW'(1);
      else if (do_rd && !do_wr) fill <= fill - NW'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfp_back.sv
`default_nettype none

module cfp_back #(
  parameter int DIGITS = cfp_pkg::DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  input  wire cfp_pkg::cfp_cmd_t      q_cmd,
  input  wire logic [DIGITS-1:0][7:0] q_digits,
  cfp_out_if.source                   out_ch
);
  import cfp_pkg::*;

  localparam int BEATS = DIGITS + 3;
  localparam int IW    = $clog2(BEATS);

  logic                   busy;
  logic [IW-1:0]          idx;
  cfp_cmd_t               cmd;
  logic [DIGITS-1:0][7:0] digits;
  logic                   last_beat;
  logic [7:0]             lcd_byte;

  assign last_beat = !cmd.write || (idx == IW'(BEATS - 1));

  // Load the next job when idle or when the last beat leaves
  assign q_pop = !q_empty && (!busy || (out_ch.ready && last_beat));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ch.ready) begin
      if (last_beat) busy <= 1'b0;
      else           idx  <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_cmd;
      digits <= q_digits;
    end
  end

  // Select the byte for the current beat
  always_comb begin
    lcd_byte = '0;
    if (cmd.write) begin
      case (idx)
        IW'(BEAT_CURSOR): lcd_byte = cursor_cmd(cmd.axis);
        IW'(BEAT_LETTER): lcd_byte = 8'(KEY_X + 8'(cmd.axis));
        IW'(BEAT_EQUAL):  lcd_byte = CHAR_EQ;
        default: begin
          for (int i = 0; i < DIGITS; i++) begin
            if (idx == IW'(BEAT_DIGIT0 + i)) lcd_byte = digits[i];
          end
        end
      endcase
    end
  end

  assign out_ch.valid          = busy;
  assign out_ch.lcd_valid      = cmd.write;
  assign out_ch.lcd_is_command = cmd.write && (idx == IW'(BEAT_CURSOR));
  assign out_ch.lcd_byte       = lcd_byte;
  assign out_ch.led_on         = cmd.led;
  assign out_ch.last           = last_beat;

endmodule

`default_nettype wire
